>>> src/gb18030_supplementary_utf8_convert_core_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef GB18030_SUPPLEMENTARY_UTF8_CONVERT_CORE_MACROS_SVH
`define GB18030_SUPPLEMENTARY_UTF8_CONVERT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gbsc_pkg.sv
// Shared types and constants for the GB18030 supplementary plane converter.
package gbsc_pkg;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned RawW   = 22;  // weighted GB byte sum
  localparam int unsigned CpW    = 21;  // code point or linear index
  localparam int unsigned Q10W   = 18;  // index / 10
  localparam int unsigned Q126W  = 11;  // index / 1260
  localparam int unsigned QaW    = 8;   // index / 12600

  localparam logic [CodeW-1:0] GbLoCode  = 32'h9030_8130;
  localparam logic [CodeW-1:0] GbHiCode  = 32'hE332_9A35;
  localparam logic [CpW-1:0]   SuppFirst = 21'h01_0000;
  localparam logic [CpW-1:0]   SuppLast  = 21'h10_FFFF;
  localparam logic [7:0]       ByteABase = 8'h81;
  localparam logic [7:0]       ByteBBase = 8'h30;

  localparam int unsigned WeightA = 12600;
  localparam int unsigned WeightB = 1260;
  localparam int unsigned WeightC = 10;
  localparam int unsigned DigitB  = 10;
  localparam int unsigned DigitC  = 126;

  localparam int unsigned GbLoRaw = int'(GbLoCode[31:24]) * WeightA
                                  + int'(GbLoCode[23:16]) * WeightB
                                  + int'(GbLoCode[15:8]) * WeightC
                                  + int'(GbLoCode[7:0]);
  localparam int unsigned LinBase = int'(ByteABase) * WeightA + int'(ByteBBase) * WeightB
                                  + int'(ByteABase) * WeightC + int'(ByteBBase);
  // raw GB sum minus CpBias gives the code point
  localparam int unsigned CpBias    = GbLoRaw - int'(SuppFirst);
  // code point plus LinOffset gives the linear GB index
  localparam int unsigned LinOffset = GbLoRaw - LinBase - int'(SuppFirst);

  // ceil(2^k / d) reciprocals, exact over the operand ranges used
  localparam int unsigned Shift10  = 24;
  localparam int unsigned Recip10  = ((2 ** Shift10) + DigitB - 1) / DigitB;
  localparam int unsigned Shift126 = 24;
  localparam int unsigned Recip126 = ((2 ** Shift126) + DigitC - 1) / DigitC;
  localparam int unsigned ShiftA   = 16;
  localparam int unsigned RecipA   = ((2 ** ShiftA) + DigitB - 1) / DigitB;

  typedef enum logic {
    OpGbToUtf8 = 1'b0,
    OpUtf8ToGb = 1'b1
  } gbsc_op_e;

  typedef struct packed {
    logic     vld;
    gbsc_op_e op;
    logic     hit;
  } gbsc_ctl_t;

endpackage

>>> src/gbsc_decode.sv
// Front stages: byte weighting or UTF-8 decode, then range check and offset.
module gbsc_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic                       operation_i,
  input  logic [gbsc_pkg::CodeW-1:0] code_i,
  output gbsc_pkg::gbsc_ctl_t        ctl_o,
  output logic [gbsc_pkg::CpW-1:0]   val_o
);
  import gbsc_pkg::*;

  function automatic logic [CpW-1:0] word_to_cp(input logic [CodeW-1:0] w);
    logic [CpW-1:0] cp;
    cp = '0;
    priority if (w[31:7] == '0) begin
      cp = CpW'(w[6:0]);
    end else if (w[31:16] == '0) begin
      cp = CpW'({w[12:8], w[5:0]});
    end else if (w[31:24] == '0) begin
      cp = CpW'({w[19:16], w[13:8], w[5:0]});
    end else begin
      cp = {w[26:24], w[21:16], w[13:8], w[5:0]};
    end
    return cp;
  endfunction

  gbsc_ctl_t         ctl1_d, ctl1_q, ctl2_d, ctl2_q;
  logic [RawW-1:0]   val1_d, val1_q;
  logic [CpW-1:0]    val2_d, val2_q;
  logic [RawW-1:0]   raw_sum;
  logic              gb_in_range;
  logic [CpW-1:0]    cp1;
  logic [RawW-1:0]   cp0_wide;

  // Stage 1: weighted byte sum for GB input, decoded code point for UTF-8
  always_comb begin
    raw_sum = RawW'(code_i[31:24]) * RawW'(WeightA)
            + RawW'(code_i[23:16]) * RawW'(WeightB)
            + RawW'(code_i[15:8]) * RawW'(WeightC)
            + RawW'(code_i[7:0]);
    gb_in_range = (code_i >= GbLoCode) && (code_i <= GbHiCode);
    ctl1_d.vld  = vld_i;
    ctl1_d.op   = gbsc_op_e'(operation_i);
    ctl1_d.hit  = gb_in_range;
    val1_d      = (ctl1_d.op == OpUtf8ToGb) ? RawW'(word_to_cp(code_i)) : raw_sum;
  end

  // Stage 2: offset to code point or to linear index, settle the mapped flag
  always_comb begin
    cp0_wide = val1_q - RawW'(CpBias);
    cp1      = val1_q[CpW-1:0];
    ctl2_d   = ctl1_q;
    if (ctl1_q.op == OpUtf8ToGb) begin
      ctl2_d.hit = (cp1 >= SuppFirst) && (cp1 <= SuppLast);
      val2_d     = cp1 + CpW'(LinOffset);
    end else begin
      val2_d     = cp0_wide[CpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val1_q <= val1_d;
    val2_q <= val2_d;
  end

  assign ctl_o = ctl2_q;
  assign val_o = val2_q;

endmodule

>>> src/gbsc_digits.sv
// Middle stages: reciprocal division into GB digits, UTF-8 packing alongside.
module gbsc_digits (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbsc_pkg::gbsc_ctl_t        ctl_i,
  input  logic [gbsc_pkg::CpW-1:0]   val_i,
  output gbsc_pkg::gbsc_ctl_t        ctl_o,
  output logic [gbsc_pkg::CodeW-1:0] utf_o,
  output logic [gbsc_pkg::QaW-1:0]   qa_o,
  output logic [gbsc_pkg::Q126W-1:0] q126_o,
  output logic [6:0]                 c_o,
  output logic [3:0]                 d_o
);
  import gbsc_pkg::*;

  localparam int unsigned P10W  = CpW + Q10W + 3;
  localparam int unsigned P126W = Q10W + Q10W;
  localparam int unsigned PaW   = Q126W + 13;

  function automatic logic [CodeW-1:0] cp_to_word(input logic [CpW-1:0] u);
    logic [CodeW-1:0] w;
    w = '0;
    priority if (u[CpW-1:7] == '0) begin
      w = CodeW'(u[6:0]);
    end else if (u[CpW-1:11] == '0) begin
      w = CodeW'({3'b110, u[10:6], 2'b10, u[5:0]});
    end else if (u[CpW-1:16] == '0) begin
      w = CodeW'({4'b1110, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]});
    end else begin
      w = {5'b11110, u[20:18], 2'b10, u[17:12], 2'b10, u[11:6], 2'b10, u[5:0]};
    end
    return w;
  endfunction

  gbsc_ctl_t          ctl3_q, ctl4_q, ctl5_q;
  logic [CpW-1:0]     n3_q;
  logic [Q10W-1:0]    q10_3_d, q10_3_q, q10_4_q;
  logic [Q126W-1:0]   q126_4_d, q126_4_q, q126_5_q;
  logic [QaW-1:0]     qa5_d, qa5_q;
  logic [3:0]         d4_d, d4_q, d5_q;
  logic [6:0]         c5_d, c5_q;
  logic [CodeW-1:0]   utf3_q, utf4_q, utf5_q;
  logic [P10W-1:0]    prod10;
  logic [P126W-1:0]   prod126;
  logic [PaW-1:0]     proda;
  logic [CpW-1:0]     n_rem;
  logic [Q10W-1:0]    q10_rem;

  always_comb begin
    // stage 3: index / 10
    prod10  = P10W'(val_i) * P10W'(Recip10);
    q10_3_d = prod10[Shift10 +: Q10W];
    // stage 4: index % 10 and index / 1260
    n_rem    = n3_q - CpW'(q10_3_q) * CpW'(DigitB);
    d4_d     = n_rem[3:0];
    prod126  = P126W'(q10_3_q) * P126W'(Recip126);
    q126_4_d = prod126[Shift126 +: Q126W];
    // stage 5: (index / 10) % 126 and index / 12600
    q10_rem = q10_4_q - Q10W'(q126_4_q) * Q10W'(DigitC);
    c5_d    = q10_rem[6:0];
    proda   = PaW'(q126_4_q) * PaW'(RecipA);
    qa5_d   = proda[ShiftA +: QaW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n3_q     <= val_i;
    q10_3_q  <= q10_3_d;
    utf3_q   <= cp_to_word(val_i);
    d4_q     <= d4_d;
    q10_4_q  <= q10_3_q;
    q126_4_q <= q126_4_d;
    utf4_q   <= utf3_q;
    d5_q     <= d4_q;
    c5_q     <= c5_d;
    q126_5_q <= q126_4_q;
    qa5_q    <= qa5_d;
    utf5_q   <= utf4_q;
  end

  assign ctl_o  = ctl5_q;
  assign utf_o  = utf5_q;
  assign qa_o   = qa5_q;
  assign q126_o = q126_5_q;
  assign c_o    = c5_q;
  assign d_o    = d5_q;

endmodule

>>> src/gb18030_supplementary_utf8_convert_core.sv
// Throughput: one command per cycle; busy_o stays low and results are never held.
// The depth is set by six register stages: decode, offset, three reciprocal
// division steps (/10, /126, /10), and the output register.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; items in flight are dropped.
`include "gb18030_supplementary_utf8_convert_core_macros.svh"

module gb18030_supplementary_utf8_convert_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       operation_i,
  input  logic [gbsc_pkg::CodeW-1:0] code_i,
  output logic                       done_o,
  output logic [gbsc_pkg::CodeW-1:0] result_word_o,
  output logic                       mapped_o
);
  import gbsc_pkg::*;

  gbsc_ctl_t         fe_ctl, dg_ctl;
  logic [CpW-1:0]    fe_val;
  logic [CodeW-1:0]  dg_utf;
  logic [QaW-1:0]    dg_qa;
  logic [Q126W-1:0]  dg_q126;
  logic [6:0]        dg_c;
  logic [3:0]        dg_d;
  logic [Q126W-1:0]  q126_rem;
  logic [3:0]        gb_b;
  logic [CodeW-1:0]  gb_word;
  logic              done_d, done_q;
  logic              mapped_d, mapped_q;
  logic [CodeW-1:0]  result_d, result_q;

  assign busy_o = 1'b0;

  gbsc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start_i & ~busy_o),
    .operation_i (operation_i),
    .code_i      (code_i),
    .ctl_o       (fe_ctl),
    .val_o       (fe_val)
  );

  gbsc_digits u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fe_ctl),
    .val_i  (fe_val),
    .ctl_o  (dg_ctl),
    .utf_o  (dg_utf),
    .qa_o   (dg_qa),
    .q126_o (dg_q126),
    .c_o    (dg_c),
    .d_o    (dg_d)
  );

  // Finish the second digit, pack the GB bytes and pick the direction, or zero an unmapped result
  always_comb begin
    q126_rem = dg_q126 - Q126W'(dg_qa) * Q126W'(DigitB);
    gb_b     = q126_rem[3:0];
    gb_word  = {ByteABase + dg_qa,
                ByteBBase + 8'(gb_b),
                ByteABase + 8'(dg_c),
                ByteBBase + 8'(dg_d)};
    done_d   = dg_ctl.vld;
    mapped_d = dg_ctl.hit;
    if (!dg_ctl.hit) begin
      result_d = '0;
    end else if (dg_ctl.op == OpUtf8ToGb) begin
      result_d = gb_word;
    end else begin
      result_d = dg_utf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mapped_q <= mapped_d;
    result_q <= result_d;
  end

  assign done_o        = done_q;
  assign mapped_o      = mapped_q;
  assign result_word_o = result_q;

  `GBSC_ASSERT_NOW(a_done_after_accept, done_o, $past(start_i && !busy_o, 6), "result strobe without a command taken six cycles before")
  `GBSC_ASSERT_NEXT(a_stage_reaches_out, dg_ctl.vld, done_o, "digit stage item lost before output")
  `GBSC_ASSERT_NOW(a_unmapped_zero, done_o && !mapped_o, result_word_o == '0, "unmapped result is not zero")
  `GBSC_ASSERT_NOW(a_gb_digits_legal, dg_ctl.vld && dg_ctl.hit && (dg_ctl.op == OpUtf8ToGb), (dg_d < 4'd10) && (dg_c < 7'd126) && (gb_b < 4'd10) && (dg_qa <= 8'd98), "GB digit out of range")

endmodule
